// ===== rtl/ptc_pkg.sv =====
// shared types and constants of the pointer to touch event converter
`timescale 1ns / 1ps

package ptc_pkg;

    // pixel coordinate and frame size width
    localparam int COORD_BITS = 12;

    // configuration port
    localparam int CFG_DATA_W = COORD_BITS;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = CFG_DATA_W'(480);
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = CFG_DATA_W'(800);
    localparam logic [1:0]            RST_ROTATION     = 2'd0;

    // event record codes
    localparam logic [1:0] TYPE_SYNC = 2'd0;
    localparam logic [1:0] TYPE_KEY  = 2'd1;
    localparam logic [1:0] TYPE_ABS  = 2'd3;

    localparam logic [8:0] CODE_X     = 9'd0;
    localparam logic [8:0] CODE_Y     = 9'd1;
    localparam logic [8:0] CODE_SYNC  = 9'd0;
    localparam logic [8:0] CODE_TOUCH = 9'd330;

    typedef struct packed {
        logic                  left_button;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         event_type;
        logic [8:0]         event_code;
        logic signed [15:0] event_value;
        logic               last_event;
    } t_out_item;

endpackage

// ===== rtl/pointer_to_touch_event_converter.sv =====
// top level: pointer events in, touchscreen event records out
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one pointer
//   item: left button, x, y. Output channel (o_out_valid / i_out_ready /
//   o_out_data) gives 0, 2, 3 or 4 event records per item, the final one
//   flagged by last_event. Frame size and rotation are written on the plain
//   write port (i_cfg_we, i_cfg_idx, i_cfg_data) while the block is idle;
//   the user is bound to this, the block itself does not enforce it.
//   One item is worked by a sequencer around one bit-serial divider and one
//   shared multiplier, with NW = 2*COORD_BITS + FRAC_BITS (40 by default)
//   bit dividends. Two divisions give the axis ratios; when the dead band
//   applies (rotated aspect), a third checks the band and a point outside
//   it is dropped, while a point inside takes a fourth for the rescale.
//   Records leave one a cycle while the receiver keeps taking them.
//   o_in_ready is high only while the sequencer is idle; the last record may
//   still wait in the output register while the next item is accepted.
//   Reset restores 480 x 800, rotation 0 and the not-touching state.
//   A stalled receiver holds the record in the output register and the
//   sequencer waits.
//
module pointer_to_touch_event_converter #(
    parameter int FRAC_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ptc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ptc_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CB = ptc_pkg::COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int NW = 2 * CB + F;
    localparam int DV = 2 * CB;
    localparam int PW = CB + NW;
    localparam int AW = PW + 1;

    localparam logic signed [AW-1:0] SAT_MAX = AW'(32767);
    localparam logic signed [AW-1:0] SAT_MIN = -AW'(32768);

    typedef enum logic [3:0] {
        S_IDLE, S_DRX, S_DRY, S_MX, S_FX, S_MY, S_FY,
        S_MA, S_MB, S_DB, S_DS, S_MS, S_FS, S_EMIT
    } t_state;

    t_state             r_state;
    logic [CB-1:0]      r_width;
    logic [CB-1:0]      r_height;
    logic [1:0]         r_rot;
    logic               r_touch;
    logic               r_button;
    logic [CB-1:0]      r_x;
    logic [CB-1:0]      r_y;
    logic [NW-1:0]      r_rx;
    logic [NW-1:0]      r_ry;
    logic [PW-1:0]      r_prod;
    logic [DV-1:0]      r_aa;
    logic [DV-1:0]      r_bb;
    logic [NW-1:0]      r_scale;
    logic signed [AW-1:0] r_ox;
    logic signed [AW-1:0] r_oy;
    logic               r_div_start;
    logic [1:0]         r_k;
    logic               r_out_valid;
    ptc_pkg::t_out_item r_out;

    logic [CB-1:0]      w, h, t, half, a, b;
    logic               need_band;
    logic signed [CB:0] dx, dy;
    logic [NW-1:0]      rsel_x, rsel_y;
    logic [CB-1:0]      ma;
    logic [NW-1:0]      mb;
    logic [PW-1:0]      prod;
    logic [NW-1:0]      div_num;
    logic [DV-1:0]      div_den;
    logic               div_done;
    logic [NW-1:0]      div_q;
    logic               cur_neg;
    logic signed [AW-1:0] axis_v, axis_abs, axis_res;
    logic signed [AW-1:0] tgt;
    logic [AW-1:0]      tgt_mag;
    logic               in_band;
    logic signed [AW-1:0] scaled;
    logic [2:0]         n_rec;
    ptc_pkg::t_out_item rec;
    logic               load;

    // frame geometry, zero size acts as one
    assign w         = (r_width == '0) ? CB'(1) : r_width;
    assign h         = (r_height == '0) ? CB'(1) : r_height;
    assign t         = (w > h) ? w : h;
    assign half      = t >> 1;
    assign a         = (w > h) ? h : w;
    assign b         = (w > h) ? w : h;
    assign need_band = (w <= h) ? r_rot[0] : !r_rot[0];

    // signed pixel distances per rotation
    always_comb begin
        case (r_rot)
            2'd0: begin
                dx = $signed({1'b0, r_x});
                dy = $signed({1'b0, r_y});
            end
            2'd1: begin
                dx = $signed({1'b0, h}) - $signed({1'b0, r_y});
                dy = $signed({1'b0, r_x});
            end
            2'd2: begin
                dx = $signed({1'b0, w}) - $signed({1'b0, r_x});
                dy = $signed({1'b0, h}) - $signed({1'b0, r_y});
            end
            default: begin
                dx = $signed({1'b0, r_y});
                dy = $signed({1'b0, w}) - $signed({1'b0, r_x});
            end
        endcase
        rsel_x = r_rot[0] ? r_ry : r_rx;
        rsel_y = r_rot[0] ? r_rx : r_ry;
    end

    // shared multiplier operands
    always_comb begin
        case (r_state)
            S_MX: begin
                ma = dx[CB] ? CB'(-dx) : dx[CB-1:0];
                mb = rsel_x;
            end
            S_MY: begin
                ma = dy[CB] ? CB'(-dy) : dy[CB-1:0];
                mb = rsel_y;
            end
            S_MA: begin
                ma = a;
                mb = NW'(a);
            end
            S_MB: begin
                ma = b;
                mb = NW'(b);
            end
            S_MS: begin
                ma = tgt_mag[CB-1:0];
                mb = r_scale;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = PW'(ma) * PW'(mb);

    // divider operands
    always_comb begin
        case (r_state)
            S_DRX: begin
                div_num = NW'(t) << F;
                div_den = DV'(w);
            end
            S_DRY: begin
                div_num = NW'(t) << F;
                div_den = DV'(h);
            end
            S_DB: begin
                div_num = NW'(r_aa) << F;
                div_den = DV'({b, 1'b0});
            end
            S_DS: begin
                div_num = NW'(r_bb) << F;
                div_den = r_aa;
            end
            default: begin
                div_num = '0;
                div_den = DV'(1);
            end
        endcase
    end

    ptc_div #(
        .NW(NW),
        .DV(DV)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_dividend(div_num),
        .i_divisor (div_den),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    // axis value: signed product minus center offset, truncated toward zero
    assign cur_neg  = (r_state == S_FX) ? dx[CB] : dy[CB];
    assign axis_v   = (cur_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod}))
                      - $signed(AW'(half) << F);
    assign axis_abs = axis_v[AW-1] ? -axis_v : axis_v;
    assign axis_res = axis_v[AW-1] ? -(axis_abs >>> F) : (axis_abs >>> F);

    // dead band target and check
    assign tgt     = r_rot[0] ? r_oy : r_ox;
    assign tgt_mag = tgt[AW-1] ? AW'(-tgt) : AW'(tgt);
    assign in_band = {tgt_mag, {F{1'b0}}} <= (AW + F)'(div_q);
    assign scaled  = tgt[AW-1] ? -$signed(AW'(r_prod >> F)) : $signed(AW'(r_prod >> F));

    // record list of this item
    always_comb begin
        if (r_button) begin
            n_rec = r_touch ? 3'd3 : 3'd4;
        end else begin
            n_rec = r_touch ? 3'd2 : 3'd0;
        end
        rec = '0;
        if (r_button) begin
            case (r_k)
                2'd0: begin
                    rec.event_type  = ptc_pkg::TYPE_ABS;
                    rec.event_code  = ptc_pkg::CODE_X;
                    rec.event_value = (r_ox > SAT_MAX) ? 16'sh7fff :
                                      (r_ox < SAT_MIN) ? -16'sh8000 : r_ox[15:0];
                end
                2'd1: begin
                    rec.event_type  = ptc_pkg::TYPE_ABS;
                    rec.event_code  = ptc_pkg::CODE_Y;
                    rec.event_value = (r_oy > SAT_MAX) ? 16'sh7fff :
                                      (r_oy < SAT_MIN) ? -16'sh8000 : r_oy[15:0];
                end
                2'd2: begin
                    if (!r_touch) begin
                        rec.event_type  = ptc_pkg::TYPE_KEY;
                        rec.event_code  = ptc_pkg::CODE_TOUCH;
                        rec.event_value = 16'sd1;
                    end else begin
                        rec.event_type = ptc_pkg::TYPE_SYNC;
                        rec.event_code = ptc_pkg::CODE_SYNC;
                    end
                end
                default: begin
                    rec.event_type = ptc_pkg::TYPE_SYNC;
                    rec.event_code = ptc_pkg::CODE_SYNC;
                end
            endcase
        end else begin
            if (r_k == 2'd0) begin
                rec.event_type  = ptc_pkg::TYPE_KEY;
                rec.event_code  = ptc_pkg::CODE_TOUCH;
                rec.event_value = 16'sd0;
            end else begin
                rec.event_type = ptc_pkg::TYPE_SYNC;
                rec.event_code = ptc_pkg::CODE_SYNC;
            end
        end
        rec.last_event = ({1'b0, r_k} == n_rec - 3'd1);
    end

    assign load = (r_state == S_EMIT) && (n_rec != 3'd0) && (!r_out_valid || i_out_ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CB'(ptc_pkg::RST_FRAME_WIDTH);
            r_height <= CB'(ptc_pkg::RST_FRAME_HEIGHT);
            r_rot    <= ptc_pkg::RST_ROTATION;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptc_pkg::CFG_FRAME_WIDTH:  r_width  <= CB'(i_cfg_data);
                ptc_pkg::CFG_FRAME_HEIGHT: r_height <= CB'(i_cfg_data);
                ptc_pkg::CFG_ROTATION:     r_rot    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_touch     <= 1'b0;
            r_div_start <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // output register: filled by the sequencer, emptied once taken
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state     <= S_DRX;
                        r_div_start <= 1'b1;
                    end
                end
                S_DRX: begin
                    if (div_done) begin
                        r_state     <= S_DRY;
                        r_div_start <= 1'b1;
                    end
                end
                S_DRY: begin
                    if (div_done) begin
                        r_state <= S_MX;
                    end
                end
                S_MX: r_state <= S_FX;
                S_FX: r_state <= S_MY;
                S_MY: r_state <= S_FY;
                S_FY: begin
                    r_k     <= '0;
                    r_state <= need_band ? S_MA : S_EMIT;
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_state     <= S_DB;
                    r_div_start <= 1'b1;
                end
                S_DB: begin
                    if (div_done) begin
                        if (in_band) begin
                            r_state     <= S_DS;
                            r_div_start <= 1'b1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DS: begin
                    if (div_done) begin
                        r_state <= S_MS;
                    end
                end
                S_MS: r_state <= S_FS;
                S_FS: r_state <= S_EMIT;
                S_EMIT: begin
                    if (n_rec == 3'd0) begin
                        r_state <= S_IDLE;
                    end else if (load) begin
                        r_out <= rec;
                        r_k   <= r_k + 1'b1;
                        if (rec.last_event) begin
                            r_touch <= r_button;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_button <= i_in_data.left_button;
                    r_x      <= CB'(i_in_data.pos_x);
                    r_y      <= CB'(i_in_data.pos_y);
                end
            end
            S_DRX: if (div_done) r_rx <= div_q;
            S_DRY: if (div_done) r_ry <= div_q;
            S_MX, S_MY, S_MA, S_MS: r_prod <= prod;
            S_FX: r_ox <= axis_res;
            S_FY: r_oy <= axis_res;
            S_MB: begin
                r_aa   <= r_prod[DV-1:0];
                r_prod <= prod;
            end
            S_DB: r_bb <= r_prod[DV-1:0];
            S_DS: if (div_done) r_scale <= div_q;
            S_FS: begin
                if (r_rot[0]) begin
                    r_oy <= scaled;
                end else begin
                    r_ox <= scaled;
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/ptc_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ptc_div #(
    parameter int NW = 40,
    parameter int DV = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DV-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DV-1:0] r_rem;
    logic [DV-1:0] r_div;
    logic [NW-1:0] r_q;
    logic [DV:0]   trial;
    logic          fits;

    // trial subtract of the next dividend bit
    assign trial = {r_rem, r_q[NW-1]};
    assign fits  = trial >= {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? DV'(trial - {1'b0, r_div}) : trial[DV-1:0];
            r_q   <= {r_q[NW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/ptc_chk.sv =====
// port checker for the pointer to touch event converter, with its bind
`timescale 1ns / 1ps

module ptc_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input ptc_pkg::t_in_item              i_in_data,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input ptc_pkg::t_out_item             o_out_data,
    input logic                           i_cfg_we,
    input logic [ptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled record stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    // a stalled record does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output item changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // every run ends in exactly one sync record
    a_sync_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_out_data.event_type == ptc_pkg::TYPE_SYNC) == o_out_data.last_event))
        else $error("sync and last flag disagree");

endmodule

bind pointer_to_touch_event_converter ptc_chk u_ptc_chk (.*);

// ===== dv/ptc_checker.sv =====
// checker for the pointer to touch event converter: predicts and compares records
`timescale 1ns / 1ps

module ptc_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  ptc_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  ptc_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ptc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_records,
    output int                             o_dropped
);

    localparam int FRAC = 16;

    // shadow of the block's registers and touch state
    logic [ptc_pkg::COORD_BITS-1:0] frame_w;
    logic [ptc_pkg::COORD_BITS-1:0] frame_h;
    logic [1:0]                     rot;
    logic                           touching;

    ptc_pkg::t_out_item record_q[$];

    function automatic longint trunc_frac(longint v);
        if (v >= 0) return v >>> FRAC;
        return -((-v) >>> FRAC);
    endfunction

    function automatic longint axis_pos(longint d, longint ratio, longint half);
        return trunc_frac(d * ratio - (half <<< FRAC));
    endfunction

    function automatic bit within_band(longint v, longint unsigned bound);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        return (mag << FRAC) <= bound;
    endfunction

    function automatic longint rescale(longint v, longint unsigned factor);
        longint unsigned mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r = longint'((mag * factor) >> FRAC);
        return (v < 0) ? -r : r;
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic ptc_pkg::t_out_item mk_rec(logic [1:0] ty, logic [8:0] code,
                                                  logic signed [15:0] val);
        ptc_pkg::t_out_item r;
        r.event_type  = ty;
        r.event_code  = code;
        r.event_value = val;
        r.last_event  = 1'b0;
        return r;
    endfunction

    // work out the records one pointer item causes
    task automatic predict_records(input ptc_pkg::t_in_item it);
        longint w, h, t, half, rx, ry, x, y, ox, oy;
        longint unsigned uw, uh;
        ptc_pkg::t_out_item recs[$];
        w = (frame_w == 0) ? 1 : frame_w;
        h = (frame_h == 0) ? 1 : frame_h;
        uw = w;
        uh = h;
        t = (w > h) ? w : h;
        half = t >> 1;
        rx = (t <<< FRAC) / w;
        ry = (t <<< FRAC) / h;
        x = it.pos_x;
        y = it.pos_y;
        case (rot)
            2'd0: begin
                ox = axis_pos(x, rx, half);
                oy = axis_pos(y, ry, half);
            end
            2'd1: begin
                oy = axis_pos(x, rx, half);
                ox = axis_pos(h - y, ry, half);
            end
            2'd2: begin
                ox = axis_pos(w - x, rx, half);
                oy = axis_pos(h - y, ry, half);
            end
            default: begin
                ox = axis_pos(y, ry, half);
                oy = axis_pos(w - x, rx, half);
            end
        endcase
        // dead band when panel and display orientation disagree
        if (w <= h) begin
            if (rot[0]) begin
                if (!within_band(oy, ((uw * uw) << FRAC) / (2 * uh))) begin
                    o_dropped++;
                    return;
                end
                oy = rescale(oy, ((uh * uh) << FRAC) / (uw * uw));
            end
        end else begin
            if (!rot[0]) begin
                if (!within_band(ox, ((uh * uh) << FRAC) / (2 * uw))) begin
                    o_dropped++;
                    return;
                end
                ox = rescale(ox, ((uw * uw) << FRAC) / (uh * uh));
            end
        end
        if (it.left_button) begin
            recs.push_back(mk_rec(ptc_pkg::TYPE_ABS, ptc_pkg::CODE_X, clip16(ox)));
            recs.push_back(mk_rec(ptc_pkg::TYPE_ABS, ptc_pkg::CODE_Y, clip16(oy)));
            if (!touching) begin
                touching = 1'b1;
                recs.push_back(mk_rec(ptc_pkg::TYPE_KEY, ptc_pkg::CODE_TOUCH, 16'sd1));
            end
            recs.push_back(mk_rec(ptc_pkg::TYPE_SYNC, ptc_pkg::CODE_SYNC, 16'sd0));
        end else if (touching) begin
            touching = 1'b0;
            recs.push_back(mk_rec(ptc_pkg::TYPE_KEY, ptc_pkg::CODE_TOUCH, 16'sd0));
            recs.push_back(mk_rec(ptc_pkg::TYPE_SYNC, ptc_pkg::CODE_SYNC, 16'sd0));
        end
        if (recs.size() > 0) recs[recs.size()-1].last_event = 1'b1;
        foreach (recs[k]) record_q.push_back(recs[k]);
    endtask

    // watch config, input and output channels
    always @(posedge i_clk) begin
        ptc_pkg::t_out_item want;
        if (!i_rst_n) begin
            frame_w      <= ptc_pkg::RST_FRAME_WIDTH;
            frame_h      <= ptc_pkg::RST_FRAME_HEIGHT;
            rot          <= ptc_pkg::RST_ROTATION;
            touching     = 1'b0;
            record_q.delete();
            o_fail_count <= 0;
            o_records    <= 0;
            o_dropped    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ptc_pkg::CFG_FRAME_WIDTH:  frame_w <= i_cfg_data;
                    ptc_pkg::CFG_FRAME_HEIGHT: frame_h <= i_cfg_data;
                    ptc_pkg::CFG_ROTATION:     rot     <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) predict_records(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_records <= o_records + 1;
                if (record_q.size() == 0) begin
                    $display("%0t: unexpected record, expected none, got %p",
                             $time, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = record_q.pop_front();
                    if (i_out_data !== want) begin
                        $display("%0t: record mismatch, expected %p, got %p",
                                 $time, want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= record_q.size();
    end

endmodule

// ===== dv/tb.sv =====
// testbench top: stimulus, idling and verdict for the pointer to touch converter
`timescale 1ns / 1ps

module tb;

    localparam int CW = ptc_pkg::COORD_BITS;
    localparam logic [ptc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    ptc_pkg::t_in_item              in_data = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    ptc_pkg::t_out_item             out_data;
    logic                           cfg_we = 1'b0;
    logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_idx = ptc_pkg::CFG_FRAME_WIDTH;
    logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    int                             fail_count, pending, records, dropped;
    int                             items_sent = 0;
    bit                             quiet = 1'b0;
    int                             cur_w = 480, cur_h = 800;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    pointer_to_touch_event_converter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    ptc_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_records   (records),
        .o_dropped   (dropped)
    );

    // receiver stalls in random bursts
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            out_ready <= i_rst_n;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // hand one pointer item to the block, called at a falling edge
    task automatic send_item(input bit btn, input int x, input int y);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data.left_button <= btn;
        in_data.pos_x <= x[CW-1:0];
        in_data.pos_y <= y[CW-1:0];
        while (!in_ready) @(negedge i_clk);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [ptc_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val[ptc_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // let all records out, then cover items that cause none
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic set_frame(input int w, input int h, input int r);
        write_reg(ptc_pkg::CFG_FRAME_WIDTH, w);
        write_reg(ptc_pkg::CFG_FRAME_HEIGHT, h);
        // rotation upper bits are junk that the block must mask
        write_reg(ptc_pkg::CFG_ROTATION, ($urandom_range(0, 1023) << 2) | r);
        cur_w = w;
        cur_h = h;
    endtask

    function automatic int pick_coord(input int lim);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, (lim > 0) ? lim : 1);
    endfunction

    // gestures of press, moves, release with random points, plus noise
    task automatic gestures(input int n);
        int moves;
        while (n > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
                n--;
            end else begin
                moves = $urandom_range(0, 5);
                send_item(1'b1, pick_coord(cur_w), pick_coord(cur_h));
                repeat (moves) send_item(1'b1, pick_coord(cur_w), pick_coord(cur_h));
                send_item(1'b0, pick_coord(cur_w), pick_coord(cur_h));
                n -= moves + 2;
            end
        end
    endtask

    initial begin
        int cfg_w[11] = '{480, 480, 480, 800, 800, 800, 4095, 1, 0, 4095, 640};
        int cfg_h[11] = '{800, 800, 800, 480, 480, 480, 1, 4095, 0, 4095, 4095};
        int cfg_r[11] = '{1, 2, 3, 0, 2, 1, 0, 3, 2, 1, 0};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset frame, extremes, press/move/release/idle
        send_item(1'b1, 0, 0);
        send_item(1'b1, 4095, 4095);
        send_item(1'b1, 479, 799);
        send_item(1'b0, 240, 400);
        send_item(1'b0, 4095, 0);
        send_item(1'b1, 2730, 1365);
        send_item(1'b0, 0, 4095);
        // ignored register index
        settle();
        write_reg(CFG_UNUSED_IDX, 12'hfff);
        // dead band on rotated portrait, presses and releases inside the band are kept
        set_frame(480, 800, 1);
        send_item(1'b1, 240, 400);
        send_item(1'b1, 240, 0);
        send_item(1'b0, 240, 799);
        send_item(1'b0, 240, 400);
        settle();
        // zero sizes act as one, past the frame saturates
        set_frame(0, 0, 2);
        send_item(1'b1, 4095, 4095);
        send_item(1'b1, 0, 0);
        send_item(1'b0, 1, 1);
        settle();
        set_frame(4095, 1, 3);
        send_item(1'b1, 0, 4095);
        send_item(1'b0, 4095, 0);
        settle();

        // random phases across frame settings, last one without idling
        for (int p = 0; p < 11; p++) begin
            set_frame(cfg_w[p], cfg_h[p], cfg_r[p]);
            if (p == 10) quiet = 1'b1;
            gestures(37);
            send_item(1'b0, 0, 0);
            settle();
        end

        $display("tb: %0d pointer items over the reset frame and 14 written setups",
                 items_sent);
        $display("tb: %0d records checked, %0d points dropped in the dead band",
                 records, dropped);
        if (fail_count == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
